// ===== design/prat_pkg.sv =====
// prat_pkg: shared types and constants for the peer report aging max table
// no dependencies; imported by peer_report_aging_max_table_unit
`timescale 1ns / 1ps
`default_nettype none

package prat_pkg;

    localparam int DELAY_W   = 7;
    localparam int LEVEL_W   = 8;
    localparam int FRAME_W   = 31;
    localparam int PSLOT_W   = 3;
    localparam int OSLOT_W   = 4;
    localparam int AGE_W     = 16;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT = 1'd1;

    localparam logic [AGE_W-1:0]   AGE_LIMIT_RST = 16'd30;
    localparam logic [OSLOT_W-1:0] NO_SLOT       = 4'hF;

    // one table entry as held in the slot memory
    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic [LEVEL_W-1:0] level;
        logic [FRAME_W-1:0] frame;
    } entry_t;

endpackage

`default_nettype wire

// ===== design/peer_report_aging_max_table_unit.sv =====
// peer_report_aging_max_table_unit: slot table of peer reports with aging and max search
// depends on prat_pkg (entry type, widths, register indexes)
`timescale 1ns / 1ps
`default_nettype none

// usage
//   configuration: cfg_we / cfg_index / cfg_wdata; index 0 is enabled, index 1 is
//   age_limit; write only while no transaction is in flight
//   input channel in_valid / in_stall carries one peer report per transaction;
//   a report is dropped (no result) when disabled, when max_ahead is zero or when
//   player_slot lies beyond the table
//   a handled report is written into its slot, then the slot memory is walked twice:
//   once for the newest frame, once to expire stale slots and pick the maxima
//   a handled report passes the write state, both sweeps and the done state before
//   out_valid rises; in_stall stays high all that time, since the slot memory with its
//   single read port is swept twice per report; a dropped report leaves the block idle
//   the result sits in an output register, so the next report is taken while it waits;
//   when out_stall holds a previous result the block waits before loading a new one
//   reset: the table reads as all zero through per-slot valid bits cleared at once,
//   enabled resets to 0 and age_limit to 30; no clearing sweep is needed
module peer_report_aging_max_table_unit
    import prat_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)(
    input  wire                       clk,
    input  wire                       rst_n,

    input  wire                       cfg_we,
    input  wire [CFG_IDX_W-1:0]       cfg_index,
    input  wire [AGE_W-1:0]           cfg_wdata,

    input  wire                       in_valid,
    output logic                      in_stall,
    input  wire [PSLOT_W-1:0]         player_slot,
    input  wire [DELAY_W-1:0]         max_ahead,
    input  wire [LEVEL_W-1:0]         latency_level,
    input  wire [FRAME_W-1:0]         report_frame,

    output logic                      out_valid,
    input  wire                       out_stall,
    output logic [DELAY_W-1:0]        worst_max_ahead,
    output logic [DELAY_W-1:0]        worst_rtt,
    output logic signed [OSLOT_W-1:0] worst_rtt_slot,
    output logic [LEVEL_W-1:0]        worst_level,
    output logic signed [OSLOT_W-1:0] worst_level_slot,
    output logic [FRAME_W-1:0]        newest_frame
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_WRITE    = 3'd1;
    localparam logic [2:0] ST_SCAN_NEW = 3'd2;
    localparam logic [2:0] ST_SCAN_AGE = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    // configuration registers
    logic                enabled_reg;
    logic [AGE_W-1:0]    age_limit_reg;

    // latched report
    logic [PSLOT_W-1:0]  in_slot_reg;
    logic [DELAY_W-1:0]  in_delay_reg;
    logic [LEVEL_W-1:0]  in_level_reg;
    logic [FRAME_W-1:0]  in_frame_reg;

    // slot memory with one write and one registered read port
    entry_t              slot_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] slot_vld_reg;
    entry_t              rd_data_reg;
    logic                rd_vld_bit_reg;

    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;
    entry_t              wr_data;
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;

    // sequencer and sweep state
    logic [2:0]          state_reg,       state_next;
    logic [CNT_W-1:0]    cnt_reg,         cnt_next;
    logic                pend_reg,        pend_next;
    logic [SLOT_W-1:0]   pend_idx_reg,    pend_idx_next;
    logic [FRAME_W-1:0]  newest_reg,      newest_next;
    logic [DELAY_W-1:0]  best_delay_reg,  best_delay_next;
    logic [OSLOT_W-1:0]  delay_slot_reg,  delay_slot_next;
    logic [LEVEL_W-1:0]  best_level_reg,  best_level_next;
    logic [OSLOT_W-1:0]  level_slot_reg,  level_slot_next;

    // result register
    logic                out_valid_reg;
    logic [DELAY_W-1:0]  out_delay_reg;
    logic [DELAY_W-1:0]  out_rtt_reg;
    logic [OSLOT_W-1:0]  out_dslot_reg;
    logic [LEVEL_W-1:0]  out_level_reg;
    logic [OSLOT_W-1:0]  out_lslot_reg;
    logic [FRAME_W-1:0]  out_frame_reg;

    logic                in_accept;
    logic                handle;
    logic                out_load;

    // entry as seen after the read, zero where the slot was never written
    logic [DELAY_W-1:0]  ent_delay;
    logic [LEVEL_W-1:0]  ent_level;
    logic [FRAME_W-1:0]  ent_frame;
    logic [FRAME_W-1:0]  ent_age;
    logic                ent_expired;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            age_limit_reg <= AGE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLED:   enabled_reg   <= cfg_wdata[0];
                CFG_AGE_LIMIT: age_limit_reg <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // ---------------------------------------------------------------- input side
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    // reports for slots beyond the table are dropped like zero-delay reports
    assign handle    = enabled_reg && (max_ahead != '0)
                       && (32'(player_slot) < NUM_SLOTS);

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_slot_reg  <= player_slot;
            in_delay_reg <= max_ahead;
            in_level_reg <= latency_level;
            in_frame_reg <= report_frame;
        end
    end

    // ---------------------------------------------------------------- slot memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg    <= slot_mem[rd_addr];
            rd_vld_bit_reg <= slot_vld_reg[rd_addr];
        end
    end

    // valid bits stand in for clearing the memory at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg <= '0;
        end
        else if (wr_en)
        begin
            slot_vld_reg[wr_addr] <= 1'b1;
        end
    end

    assign ent_delay   = rd_vld_bit_reg ? rd_data_reg.delay : '0;
    assign ent_level   = rd_vld_bit_reg ? rd_data_reg.level : '0;
    assign ent_frame   = rd_vld_bit_reg ? rd_data_reg.frame : '0;
    // newest is the maximum of all frames, so the difference never wraps
    assign ent_age     = newest_reg - ent_frame;
    assign ent_expired = (ent_age >= FRAME_W'(age_limit_reg));

    // read address walks the table during both sweeps
    assign rd_addr = cnt_reg[SLOT_W-1:0];
    assign rd_en   = ((state_reg == ST_SCAN_NEW) || (state_reg == ST_SCAN_AGE))
                     && (cnt_reg < CNT_W'(NUM_SLOTS));

    // write port: report write, or clearing an expired slot behind the read
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = SLOT_W'(in_slot_reg);
        wr_data = '{delay: in_delay_reg, level: in_level_reg, frame: in_frame_reg};
        if (state_reg == ST_WRITE)
        begin
            wr_en = 1'b1;
        end
        else if ((state_reg == ST_SCAN_AGE) && pend_reg && ent_expired)
        begin
            // delay and level cleared, frame kept
            wr_en   = 1'b1;
            wr_addr = pend_idx_reg;
            wr_data = '{delay: '0, level: '0, frame: ent_frame};
        end
    end

    // ---------------------------------------------------------------- sequencer
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_next       = rd_en;
        pend_idx_next   = rd_addr;
        newest_next     = newest_reg;
        best_delay_next = best_delay_reg;
        delay_slot_next = delay_slot_reg;
        best_level_next = best_level_reg;
        level_slot_next = level_slot_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && handle)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next  = ST_SCAN_NEW;
                cnt_next    = '0;
                newest_next = '0;
            end
            ST_SCAN_NEW:
            begin
                if (rd_en)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (pend_reg && (ent_frame > newest_reg))
                begin
                    newest_next = ent_frame;
                end
                // last entry arrives once every read has been issued
                if (!rd_en && pend_reg)
                begin
                    state_next      = ST_SCAN_AGE;
                    cnt_next        = '0;
                    best_delay_next = '0;
                    delay_slot_next = NO_SLOT;
                    best_level_next = '0;
                    level_slot_next = NO_SLOT;
                end
            end
            ST_SCAN_AGE:
            begin
                if (rd_en)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                // strict compare keeps the lowest slot on ties
                if (pend_reg && !ent_expired)
                begin
                    if (ent_delay > best_delay_reg)
                    begin
                        best_delay_next = ent_delay;
                        delay_slot_next = OSLOT_W'(pend_idx_reg);
                    end
                    if (ent_level > best_level_reg)
                    begin
                        best_level_next = ent_level;
                        level_slot_next = OSLOT_W'(pend_idx_reg);
                    end
                end
                if (!rd_en && pend_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg   <= pend_idx_next;
        newest_reg     <= newest_next;
        best_delay_reg <= best_delay_next;
        delay_slot_reg <= delay_slot_next;
        best_level_reg <= best_level_next;
        level_slot_reg <= level_slot_next;
    end

    // ---------------------------------------------------------------- output side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_delay_reg <= best_delay_reg;
            out_rtt_reg   <= (best_delay_reg != '0) ? (best_delay_reg - 1'b1) : '0;
            out_dslot_reg <= delay_slot_reg;
            out_level_reg <= best_level_reg;
            out_lslot_reg <= level_slot_reg;
            out_frame_reg <= newest_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign worst_max_ahead  = out_delay_reg;
    assign worst_rtt        = out_rtt_reg;
    assign worst_rtt_slot   = out_dslot_reg;
    assign worst_level      = out_level_reg;
    assign worst_level_slot = out_lslot_reg;
    assign newest_frame     = out_frame_reg;

endmodule

`default_nettype wire

// ===== test/tb_peer_report_aging_max_table_unit.sv =====
// tb_peer_report_aging_max_table_unit: self-checking testbench for the peer report table
// depends on prat_pkg and peer_report_aging_max_table_unit; needs nothing else to run
`timescale 1ns / 1ps
`default_nettype none

module tb_peer_report_aging_max_table_unit;
    import prat_pkg::*;

    localparam int NUM_SLOTS      = 8;
    localparam int BLOCK_LATENCY  = 2 * NUM_SLOTS + 4;
    localparam int RANDOM_REPORTS = 1500;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_SHOWN      = 10;
    localparam int IDLE_PERCENT   = 18;
    localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

    // one worst-case summary as the block reports it
    typedef struct packed {
        logic [DELAY_W-1:0] max_ahead;
        logic [DELAY_W-1:0] rtt;
        logic [OSLOT_W-1:0] rtt_slot;
        logic [LEVEL_W-1:0] level;
        logic [OSLOT_W-1:0] level_slot;
        logic [FRAME_W-1:0] newest;
    } worst_t;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index     = CFG_ENABLED;
    logic [AGE_W-1:0]          cfg_wdata     = '0;
    logic                      in_valid      = 1'b0;
    logic                      in_stall;
    logic [PSLOT_W-1:0]        player_slot   = '0;
    logic [DELAY_W-1:0]        max_ahead     = '0;
    logic [LEVEL_W-1:0]        latency_level = '0;
    logic [FRAME_W-1:0]        report_frame  = '0;
    logic                      out_valid;
    logic                      out_stall     = 1'b0;
    logic [DELAY_W-1:0]        worst_max_ahead;
    logic [DELAY_W-1:0]        worst_rtt;
    logic signed [OSLOT_W-1:0] worst_rtt_slot;
    logic [LEVEL_W-1:0]        worst_level;
    logic signed [OSLOT_W-1:0] worst_level_slot;
    logic [FRAME_W-1:0]        newest_frame;

    // shadow copy of the slot table and registers, at their reset values
    logic [DELAY_W-1:0] shadow_delay [NUM_SLOTS] = '{default: '0};
    logic [LEVEL_W-1:0] shadow_level [NUM_SLOTS] = '{default: '0};
    logic [FRAME_W-1:0] shadow_frame [NUM_SLOTS] = '{default: '0};
    logic               shadow_enabled   = 1'b0;
    logic [AGE_W-1:0]   shadow_age_limit = AGE_LIMIT_RST;

    worst_t      pending_worst[$];
    int unsigned accepted_reports = 0;
    int unsigned mismatch_count   = 0;
    int unsigned idle_watch       = 0;
    int          hold_left        = 0;
    bit          calm             = 1'b0;
    logic [FRAME_W-1:0] frame_clock = '0;

    peer_report_aging_max_table_unit #(
        .NUM_SLOTS(NUM_SLOTS)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .player_slot     (player_slot),
        .max_ahead       (max_ahead),
        .latency_level   (latency_level),
        .report_frame    (report_frame),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .worst_max_ahead (worst_max_ahead),
        .worst_rtt       (worst_rtt),
        .worst_rtt_slot  (worst_rtt_slot),
        .worst_level     (worst_level),
        .worst_level_slot(worst_level_slot),
        .newest_frame    (newest_frame)
    );

    always #5 clk = ~clk;

    // apply one report to the shadow table; returns 1 when the block owes a result
    function automatic bit predict_worst(input logic [PSLOT_W-1:0] slot,
                                         input logic [DELAY_W-1:0] delay,
                                         input logic [LEVEL_W-1:0] level,
                                         input logic [FRAME_W-1:0] frame,
                                         output worst_t res);
        logic [FRAME_W-1:0] newest;
        newest = '0;
        res = '{max_ahead: '0, rtt: '0, rtt_slot: NO_SLOT, level: '0,
                level_slot: NO_SLOT, newest: '0};
        // disabled, zero delay or a slot past the table: dropped, table untouched
        if (!shadow_enabled || delay == '0 || int'(slot) >= NUM_SLOTS)
            return 1'b0;
        shadow_delay[slot] = delay;
        shadow_level[slot] = level;
        shadow_frame[slot] = frame;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (shadow_frame[i] > newest)
                newest = shadow_frame[i];
        for (int i = 0; i < NUM_SLOTS; i++) begin
            // newest never trails a slot, so the gap cannot wrap;
            // a zero age limit therefore expires every slot
            if (newest - shadow_frame[i] >= shadow_age_limit) begin
                shadow_delay[i] = '0;
                shadow_level[i] = '0;
            end
            else begin
                // strict compare keeps the lowest slot on ties
                if (shadow_delay[i] > res.max_ahead) begin
                    res.max_ahead = shadow_delay[i];
                    res.rtt_slot  = OSLOT_W'(i);
                end
                if (shadow_level[i] > res.level) begin
                    res.level      = shadow_level[i];
                    res.level_slot = OSLOT_W'(i);
                end
            end
        end
        res.rtt    = (res.max_ahead != '0) ? res.max_ahead - 1'b1 : '0;
        res.newest = newest;
        return 1'b1;
    endfunction

    // one process samples every handshake: results are checked before new reports
    // are predicted, and the watchdog counts edges with no transaction at all
    always @(posedge clk) begin : scoreboard
        worst_t got;
        worst_t want;
        worst_t predicted;
        logic   in_acc;
        logic   out_acc;
        in_acc  = rst_n && in_valid && (in_stall === 1'b0);
        out_acc = rst_n && (out_valid === 1'b1) && !out_stall;
        if (out_acc) begin
            got = '{worst_max_ahead, worst_rtt, worst_rtt_slot, worst_level,
                    worst_level_slot, newest_frame};
            if (pending_worst.size() == 0) begin
                if (mismatch_count < MAX_SHOWN)
                    $display("%0t: result with nothing outstanding: ahead=%0d slot=%0d",
                             $time, got.max_ahead, $signed(got.rtt_slot));
                mismatch_count++;
            end
            else begin
                want = pending_worst.pop_front();
                if (got !== want) begin
                    if (mismatch_count < MAX_SHOWN)
                        $display("%0t: mismatch", $time,
                                 "\n  expected ahead=%0d rtt=%0d rtt_slot=%0d",
                                 want.max_ahead, want.rtt, $signed(want.rtt_slot),
                                 " level=%0d level_slot=%0d newest=%0d",
                                 want.level, $signed(want.level_slot), want.newest,
                                 "\n  actual   ahead=%0d rtt=%0d rtt_slot=%0d",
                                 got.max_ahead, got.rtt, $signed(got.rtt_slot),
                                 " level=%0d level_slot=%0d newest=%0d",
                                 got.level, $signed(got.level_slot), got.newest);
                    mismatch_count++;
                end
            end
        end
        if (rst_n && cfg_we) begin
            case (cfg_index)
                CFG_ENABLED:   shadow_enabled   = cfg_wdata[0];
                CFG_AGE_LIMIT: shadow_age_limit = cfg_wdata;
                default: ;
            endcase
        end
        if (in_acc) begin
            accepted_reports++;
            if (predict_worst(player_slot, max_ahead, latency_level, report_frame,
                              predicted))
                pending_worst.push_back(predicted);
        end
        if (in_acc || out_acc)
            idle_watch = 0;
        else
            idle_watch++;
        if (idle_watch >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side pacing: a requested hold-off first, else none in calm runs, else random stalls
    always @(posedge clk) begin : sink_pacing
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < IDLE_PERCENT);
    end

    // offer one report and return at the edge that takes it; valid stays high
    task automatic send_report(input logic [PSLOT_W-1:0] slot,
                               input logic [DELAY_W-1:0] delay,
                               input logic [LEVEL_W-1:0] level,
                               input logic [FRAME_W-1:0] frame);
        if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, $urandom_range(1) ? 3 : BLOCK_LATENCY + 4))
                @(posedge clk);
        end
        in_valid      <= 1'b1;
        player_slot   <= slot;
        max_ahead     <= delay;
        latency_level <= level;
        report_frame  <= frame;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_worst.size() != 0)
            @(posedge clk);
    endtask

    // idle point for register writes: drains every outstanding result, then idles before returning
    task automatic settle();
        drain_results();
        repeat (BLOCK_LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [AGE_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // only bit 0 counts; the upper bits carry junk
    task automatic set_enabled(input bit on);
        logic [AGE_W-1:0] word;
        word    = AGE_W'($urandom);
        word[0] = on;
        write_reg(CFG_ENABLED, word);
    endtask

    // coarse values now and then so ties between slots turn up
    function automatic logic [DELAY_W-1:0] pick_delay();
        if ($urandom_range(9) == 0)
            return '0;
        if ($urandom_range(2) == 0)
            return DELAY_W'($urandom_range(1, 4) * 31);
        return DELAY_W'($urandom_range(1, 127));
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        if ($urandom_range(2) == 0)
            return LEVEL_W'($urandom_range(0, 3) * 85);
        return LEVEL_W'($urandom);
    endfunction

    // refresh every slot near a fresh frame base, then let the frame clock run
    // with a few late reports so slots age out at varied distances
    task automatic run_well_formed(input int reports);
        int                 first;
        logic [FRAME_W-1:0] frame;
        first       = $urandom_range(0, NUM_SLOTS - 1);
        frame_clock = FRAME_W'($urandom_range(64, 32'h7FF0_0000));
        for (int k = 0; k < NUM_SLOTS; k++) begin
            send_report(PSLOT_W'((first + k) % NUM_SLOTS), DELAY_W'($urandom_range(1, 127)),
                        pick_level(), frame_clock);
            frame_clock += FRAME_W'($urandom_range(0, 1));
        end
        repeat (reports) begin
            frame_clock += FRAME_W'($urandom_range(0, 3));
            frame = frame_clock;
            if ($urandom_range(7) == 0)
                frame -= FRAME_W'($urandom_range(0, 40));
            send_report(PSLOT_W'($urandom), pick_delay(), pick_level(), frame);
        end
    endtask

    // unrelated fields everywhere, frames across the full range
    task automatic run_noise(input int reports);
        repeat (reports)
            send_report(PSLOT_W'($urandom),
                        ($urandom_range(3) == 0) ? '0 : DELAY_W'($urandom),
                        LEVEL_W'($urandom), FRAME_W'($urandom));
    endtask

    // out of reset the block is disabled: reports must vanish
    task automatic test_reset_state();
        send_report(3'd3, 7'd5, 8'd9, 31'd10);
        send_report(3'd7, 7'd127, 8'd255, FRAME_MAX);
        settle();
    endtask

    // field extremes, a zero delay, ties and the expiry boundary at the reset age
    task automatic test_table_basics();
        set_enabled(1'b1);
        send_report(3'd0, 7'd1, 8'd0, 31'd0);
        send_report(3'd7, 7'd127, 8'd255, FRAME_MAX);
        send_report(3'd3, 7'd0, 8'd77, 31'd100);
        send_report(3'd7, 7'd10, 8'd20, 31'd100);
        send_report(3'd2, 7'd40, 8'd50, 31'd100);
        send_report(3'd5, 7'd40, 8'd50, 31'd100);
        // one frame short of the limit stays, exactly at the limit expires
        send_report(3'd4, 7'd40, 8'd60, 31'd71);
        send_report(3'd6, 7'd90, 8'd90, 31'd70);
        send_report(3'd1, 7'd3, 8'd3, 31'd130);
        settle();
    endtask

    // widest, zero and one-frame age limits, then back to the reset value
    task automatic test_age_limit_extremes();
        write_reg(CFG_AGE_LIMIT, 16'hFFFF);
        send_report(3'd0, 7'd127, 8'd255, 31'd131);
        send_report(3'd6, 7'd1, 8'd1, 31'd0);
        settle();
        // nothing survives, not even the slot just written
        write_reg(CFG_AGE_LIMIT, 16'd0);
        send_report(3'd3, 7'd7, 8'd7, 31'd200);
        settle();
        write_reg(CFG_AGE_LIMIT, 16'd1);
        send_report(3'd3, 7'd8, 8'd8, 31'd200);
        send_report(3'd4, 7'd9, 8'd9, 31'd200);
        send_report(3'd5, 7'd2, 8'd2, 31'd201);
        settle();
        write_reg(CFG_AGE_LIMIT, AGE_LIMIT_RST);
    endtask

    // long stretch with neither side idling
    task automatic test_back_to_back();
        calm = 1'b1;
        run_well_formed(150);
        calm = 1'b0;
    endtask

    // receiver holds off while reports keep coming, then the sender waits it out
    task automatic test_backpressure();
        hold_left = HOLD_CYCLES;
        run_well_formed(16);
        drain_results();
        run_well_formed(10);
    endtask

    // mostly well-formed sequences under changing registers, some noise
    task automatic test_random_traffic();
        int unsigned start;
        int unsigned pick;
        start = accepted_reports;
        while (accepted_reports - start < RANDOM_REPORTS) begin
            if ($urandom_range(2) == 0) begin
                settle();
                pick = $urandom_range(9);
                case (pick)
                    0:       write_reg(CFG_AGE_LIMIT, 16'd0);
                    1:       write_reg(CFG_AGE_LIMIT, 16'd1);
                    2:       write_reg(CFG_AGE_LIMIT, 16'hFFFF);
                    3:       write_reg(CFG_AGE_LIMIT, AGE_W'($urandom));
                    default: write_reg(CFG_AGE_LIMIT, AGE_W'($urandom_range(2, 48)));
                endcase
                set_enabled($urandom_range(7) != 0);
            end
            if ($urandom_range(4) != 0)
                run_well_formed($urandom_range(10, 50));
            else
                run_noise($urandom_range(5, 20));
        end
    endtask

    initial begin : regression
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_table_basics();
        test_age_limit_extremes();
        test_back_to_back();
        test_backpressure();
        test_random_traffic();
        drain_results();
        repeat (BLOCK_LATENCY + 10) @(posedge clk);
        mismatch_count += pending_worst.size();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
